// File: hw/rtl/gtva_pkg.sv
// ----------------------------------------------------------------------------
// gtva_pkg
// Shared types and constants for the generation-tagged vector allocator.
// ----------------------------------------------------------------------------
package gtva_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int GROUP_W        = 8;          // slots per find-first leaf
  localparam logic [7:0] WINDOW_BASE_RST = 8'd64;

  // operation codes
  localparam logic [2:0] OP_INIT        = 3'd0;
  localparam logic [2:0] OP_ALLOC_ANY   = 3'd1;
  localparam logic [2:0] OP_ALLOC_NAMED = 3'd2;
  localparam logic [2:0] OP_RELEASE     = 3'd3;
  localparam logic [2:0] OP_QUERY       = 3'd4;

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_ALREADY   = 4'd1;
  localparam logic [3:0] ST_NOT_INIT  = 4'd2;
  localparam logic [3:0] ST_IRQ       = 4'd3;
  localparam logic [3:0] ST_RESERVED  = 4'd4;
  localparam logic [3:0] ST_TAKEN     = 4'd5;
  localparam logic [3:0] ST_EXHAUSTED = 4'd6;
  localparam logic [3:0] ST_DOUBLE    = 4'd7;
  localparam logic [3:0] ST_STALE     = 4'd8;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  vector;
    logic [31:0] handle_generation;
    logic        handle_active;
    logic        irq_enabled;
    logic        platform_ready;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  granted_vector;
    logic [31:0] granted_generation;
    logic        handle_active_out;
    logic        in_use;
    logic [6:0]  allocated_count;
    logic [6:0]  free_count;
  } resp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic execute;    // commit state update and result
  } ctl_cmd_t;

endpackage

// File: hw/rtl/gtva_ctrl.sv
// ----------------------------------------------------------------------------
// gtva_ctrl
// Sequencer: idle -> lookup -> select -> execute, one transaction at a time.
// ----------------------------------------------------------------------------
module gtva_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output gtva_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_SELECT = 4'b0100,
    S_EXEC   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_SELECT;
      S_SELECT: state_next = S_EXEC;
      S_EXEC:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state != S_IDLE);
  assign cmd.load    = (state == S_IDLE) && start;
  assign cmd.execute = (state == S_EXEC);

endmodule

// File: hw/rtl/gtva_datapath.sv
// ----------------------------------------------------------------------------
// gtva_datapath
// Slot state, generation memory, find-first-free tree and result logic.
// ----------------------------------------------------------------------------
module gtva_datapath #(
  parameter int SLOT_COUNT = gtva_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  gtva_pkg::ctl_cmd_t  cmd,
  input  gtva_pkg::req_t      command,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output gtva_pkg::resp_t     result,
  output logic                done
);

  localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int GW  = gtva_pkg::GROUP_W;
  localparam int GIW = $clog2(GW);
  localparam int NG  = (SLOT_COUNT + GW - 1) / GW;
  localparam int NGW = (NG > 1) ? $clog2(NG) : 1;

  // architectural state
  logic [7:0]            window_base;
  logic [SLOT_COUNT-1:0] taken;
  logic [SLOT_COUNT-1:0] gen_valid;    // clear entry reads as generation zero
  logic [31:0]           gen_mem [SLOT_COUNT];
  logic                  active;
  logic [6:0]            taken_total;
  logic [6:0]            free_total;

  gtva_pkg::req_t        req;

  // ---------------- lookup stage ----------------
  logic [7:0]            lim;
  logic [8:0]            diff;
  logic                  win_ok_c;
  logic [NG*GW-1:0]      elig_pad;
  logic [NG-1:0]         grp_any_c;
  logic [GIW-1:0]        grp_idx_c [NG];

  logic                  win_ok;
  logic [SW-1:0]         named_slot;
  logic [NG-1:0]         grp_any;
  logic [GIW-1:0]        grp_idx [NG];

  assign lim      = 8'd255 - window_base;
  assign diff     = {1'b0, req.vector} - {1'b0, window_base};
  assign win_ok_c = !diff[8] && ({1'b0, diff[7:0]} < 9'(SLOT_COUNT));

  always_comb begin
    elig_pad = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      elig_pad[i] = !taken[i] && (9'(i) <= {1'b0, lim});
    end
    for (int g = 0; g < NG; g++) begin
      grp_any_c[g] = 1'b0;
      grp_idx_c[g] = '0;
      for (int b = GW - 1; b >= 0; b--) begin
        if (elig_pad[g*GW + b]) begin
          grp_any_c[g] = 1'b1;
          grp_idx_c[g] = GIW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_ok     <= win_ok_c;
    named_slot <= diff[SW-1:0];
    grp_any    <= grp_any_c;
    grp_idx    <= grp_idx_c;
  end

  // ---------------- select stage ----------------
  logic                  found_c;
  logic [NGW-1:0]        pick_c;
  logic [NGW+GIW-1:0]    any_full;
  logic [SW-1:0]         sel_slot_c;

  logic                  sel_found;
  logic [SW-1:0]         sel_slot;
  logic                  sel_taken;
  logic                  sel_gvalid;
  logic [31:0]           rd_gen;

  always_comb begin
    found_c = 1'b0;
    pick_c  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found_c = 1'b1;
        pick_c  = NGW'(g);
      end
    end
    any_full   = {pick_c, grp_idx[pick_c]};
    sel_slot_c = (req.operation == gtva_pkg::OP_ALLOC_ANY) ? SW'(any_full) : named_slot;
  end

  always_ff @(posedge clk) begin
    sel_found  <= found_c;
    sel_slot   <= sel_slot_c;
    sel_taken  <= taken[sel_slot_c];
    sel_gvalid <= gen_valid[sel_slot_c];
    rd_gen     <= gen_mem[sel_slot_c];
  end

  // ---------------- execute stage ----------------
  gtva_pkg::resp_t       resp_c;
  logic [31:0]           cur_gen;
  logic [31:0]           bump;
  logic                  do_take;
  logic                  do_release;
  logic                  do_init;
  logic                  active_next;
  logic [6:0]            taken_total_next;
  logic [6:0]            free_total_next;

  always_comb begin
    cur_gen = sel_gvalid ? rd_gen : 32'd0;
    bump    = cur_gen + 32'd1;
    if (bump == 32'd0) begin
      bump = 32'd1;
    end

    resp_c                   = '0;
    resp_c.status            = gtva_pkg::ST_OK;
    resp_c.handle_active_out = req.handle_active;
    do_take                  = 1'b0;
    do_release               = 1'b0;
    do_init                  = 1'b0;

    unique case (req.operation)
      gtva_pkg::OP_INIT: begin
        if (active)                   resp_c.status = gtva_pkg::ST_ALREADY;
        else if (!req.platform_ready) resp_c.status = gtva_pkg::ST_NOT_INIT;
        else if (req.irq_enabled)     resp_c.status = gtva_pkg::ST_IRQ;
        else                          do_init       = 1'b1;
      end
      gtva_pkg::OP_ALLOC_ANY,
      gtva_pkg::OP_ALLOC_NAMED: begin
        resp_c.handle_active_out = 1'b0;
        if (!active)                  resp_c.status = gtva_pkg::ST_NOT_INIT;
        else if (req.irq_enabled)     resp_c.status = gtva_pkg::ST_IRQ;
        else if (req.operation == gtva_pkg::OP_ALLOC_ANY) begin
          if (sel_found) do_take       = 1'b1;
          else           resp_c.status = gtva_pkg::ST_EXHAUSTED;
        end
        else if (!win_ok)             resp_c.status = gtva_pkg::ST_RESERVED;
        else if (sel_taken)           resp_c.status = gtva_pkg::ST_TAKEN;
        else                          do_take       = 1'b1;
        if (do_take) begin
          resp_c.granted_vector     = window_base + 8'(sel_slot);
          resp_c.granted_generation = bump;
          resp_c.handle_active_out  = 1'b1;
        end
      end
      gtva_pkg::OP_RELEASE: begin
        if (!active)                  resp_c.status = gtva_pkg::ST_NOT_INIT;
        else if (req.irq_enabled)     resp_c.status = gtva_pkg::ST_IRQ;
        else if (!win_ok)             resp_c.status = gtva_pkg::ST_RESERVED;
        else if (!req.handle_active || !sel_taken)
                                      resp_c.status = gtva_pkg::ST_DOUBLE;
        else if (cur_gen != req.handle_generation)
                                      resp_c.status = gtva_pkg::ST_STALE;
        else begin
          do_release               = 1'b1;
          resp_c.handle_active_out = 1'b0;
        end
      end
      gtva_pkg::OP_QUERY: begin
        resp_c.in_use = active && win_ok && sel_taken;
      end
      default: ;  // undefined codes: no effect
    endcase

    active_next      = active | do_init;
    taken_total_next = taken_total;
    free_total_next  = free_total;
    if (do_init) begin
      taken_total_next = 7'd0;
      free_total_next  = 7'(SLOT_COUNT);
    end else if (do_take) begin
      taken_total_next = taken_total + 7'd1;
      free_total_next  = free_total - 7'd1;
    end else if (do_release) begin
      taken_total_next = taken_total - 7'd1;
      free_total_next  = free_total + 7'd1;
    end
    resp_c.allocated_count = taken_total_next;
    resp_c.free_count      = free_total_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= gtva_pkg::WINDOW_BASE_RST;
      taken       <= '0;
      gen_valid   <= '0;
      active      <= 1'b0;
      taken_total <= 7'd0;
      free_total  <= 7'd0;
      done        <= 1'b0;
    end else begin
      done <= cmd.execute;
      if (cfg_we) begin
        window_base <= cfg_data;
      end
      if (cmd.execute) begin
        active      <= active_next;
        taken_total <= taken_total_next;
        free_total  <= free_total_next;
        if (do_init) begin
          taken     <= '0;
          gen_valid <= '0;
        end
        if (do_take) begin
          taken[sel_slot]     <= 1'b1;
          gen_valid[sel_slot] <= 1'b1;
        end
        if (do_release) begin
          taken[sel_slot] <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= command;
    end
    if (cmd.execute) begin
      result <= resp_c;
    end
    if (cmd.execute && do_take) begin
      gen_mem[sel_slot] <= bump;
    end
  end

endmodule

// File: hw/rtl/generation_tagged_vector_allocator.sv
// ----------------------------------------------------------------------------
// generation_tagged_vector_allocator
// Vector allocator with per-slot in-use bit and 32-bit generation tag.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result
// appears on result with done high for exactly one cycle, after the lookup,
// select and execute states; the receiver cannot stall it, so it must
// capture result on the done cycle. busy drops in that same cycle, so a
// new command can be taken in the done cycle of the previous one. The four
// steps are: capture, window check plus per-group find-first-free, group
// select plus generation memory read, then commit and result. Every result
// carries the allocated and free counts after the operation. window_base is
// written through the cfg channel (always ready) and must only change while
// busy is low. Slot state clears instantly on reset and on a successful
// initialize; no clearing pass is needed.
// ----------------------------------------------------------------------------
module generation_tagged_vector_allocator #(
  parameter int SLOT_COUNT = gtva_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // command channel
  input  logic             start,
  output logic             busy,
  input  gtva_pkg::req_t   command,
  // result channel, single-cycle strobe
  output logic             done,
  output gtva_pkg::resp_t  result,
  // window base register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);

  gtva_pkg::ctl_cmd_t cmd;

  // register write never stalls
  assign cfg_ready = 1'b1;

  gtva_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  gtva_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .command  (command),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .result   (result),
    .done     (done)
  );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generation-tagged vector allocator. A queue of
// staged commands feeds a clocked driver. A shadow allocator in the bench
// predicts every result at acceptance. A clocked monitor compares each done
// strobe with the oldest prediction, field by field. A short directed
// sequence comes first, then random phases under several window bases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS       = gtva_pkg::SLOT_COUNT_DEF;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 340;
  localparam int IDLE_PCT     = 28;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;
  // ~2100 commands plus random gaps; many times over
  localparam int CYCLE_LIMIT  = 400_000;

  // window base per random phase (phase 0 is the last entry of the list)
  localparam logic [PHASES-1:0][7:0] PHASE_BASE =
    {8'd64, 8'd7, 8'd128, 8'd200, 8'd255, 8'd0};
  // phases that lean toward allocation (fill up and exhaust the window)
  localparam logic [PHASES-1:0] PHASE_FILLS = 6'b010101;

  // full allocator state, kept twice: once for checking, once for planning
  typedef struct packed {
    logic [7:0]               base;
    logic                     active;
    logic [NSLOTS-1:0]        taken;
    logic [NSLOTS-1:0][31:0]  gen;
    logic [6:0]               taken_cnt;
    logic [6:0]               free_cnt;
  } alloc_state_t;

  // a caller's handle: slot index and the generation it was granted
  typedef struct {
    int          slot;
    logic [31:0] gen;
  } handle_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  gtva_pkg::req_t    command = '0;
  logic              done;
  gtva_pkg::resp_t   result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = gtva_pkg::WINDOW_BASE_RST;

  alloc_state_t      model;         // advanced at each accepted transaction
  alloc_state_t      plan;          // advanced as commands are staged
  gtva_pkg::req_t    command_backlog[$];
  gtva_pkg::resp_t   pending_results[$];
  handle_t           live_handles[$];
  handle_t           retired_handles[$];

  bit      steady_feed = 1'b0; // no sender idling while set
  int      cycle_count = 0;
  int      fail_count = 0;
  int      results_checked = 0;
  int      accepted_count = 0;
  int      window_writes = 0;
  int      status_tally[16];

  generation_tagged_vector_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Allocator behavior: apply one command to a state, return its result.
  // --------------------------------------------------------------------------
  function automatic alloc_state_t cleared_state();
    alloc_state_t s;
    s = '0;
    s.base = gtva_pkg::WINDOW_BASE_RST;
    return s;
  endfunction

  function automatic gtva_pkg::resp_t apply_command(inout alloc_state_t s,
                                                    input gtva_pkg::req_t c);
    gtva_pkg::resp_t r;
    logic        hit;
    int          slot;
    int          pick;
    logic [31:0] g;
    r = '0;
    r.handle_active_out = c.handle_active;
    // vector inside [base, base + NSLOTS)
    hit  = (c.vector >= s.base) && (int'(c.vector) - int'(s.base) < NSLOTS);
    slot = hit ? int'(c.vector) - int'(s.base) : 0;
    case (c.operation)
      gtva_pkg::OP_INIT: begin
        // "already active" wins even with interrupts enabled
        if (s.active) r.status = gtva_pkg::ST_ALREADY;
        else if (!c.platform_ready) r.status = gtva_pkg::ST_NOT_INIT;
        else if (c.irq_enabled) r.status = gtva_pkg::ST_IRQ;
        else begin
          s.taken     = '0;
          s.gen       = '0;
          s.taken_cnt = '0;
          s.free_cnt  = 7'(NSLOTS);
          s.active    = 1'b1;
        end
      end
      gtva_pkg::OP_ALLOC_ANY, gtva_pkg::OP_ALLOC_NAMED: begin
        r.handle_active_out = 1'b0;
        pick = -1;
        if (!s.active) r.status = gtva_pkg::ST_NOT_INIT;
        else if (c.irq_enabled) r.status = gtva_pkg::ST_IRQ;
        else if (c.operation == gtva_pkg::OP_ALLOC_ANY) begin
          // lowest free slot whose vector still fits in eight bits
          r.status = gtva_pkg::ST_EXHAUSTED;
          for (int i = NSLOTS - 1; i >= 0; i--) begin
            if (int'(s.base) + i <= 255 && !s.taken[i]) pick = i;
          end
        end else if (!hit) r.status = gtva_pkg::ST_RESERVED;
        else if (s.taken[slot]) r.status = gtva_pkg::ST_TAKEN;
        else pick = slot;
        if (pick >= 0) begin
          // generation bump never lands on zero
          g = s.gen[pick] + 32'd1;
          if (g == '0) g = 32'd1;
          s.gen[pick]   = g;
          s.taken[pick] = 1'b1;
          s.taken_cnt   = s.taken_cnt + 7'd1;
          s.free_cnt    = s.free_cnt - 7'd1;
          r.status             = gtva_pkg::ST_OK;
          r.granted_vector     = 8'(int'(s.base) + pick);
          r.granted_generation = g;
          r.handle_active_out  = 1'b1;
        end
      end
      gtva_pkg::OP_RELEASE: begin
        if (!s.active) r.status = gtva_pkg::ST_NOT_INIT;
        else if (c.irq_enabled) r.status = gtva_pkg::ST_IRQ;
        else if (!hit) r.status = gtva_pkg::ST_RESERVED;
        else if (!c.handle_active || !s.taken[slot]) r.status = gtva_pkg::ST_DOUBLE;
        else if (s.gen[slot] != c.handle_generation) r.status = gtva_pkg::ST_STALE;
        else begin
          s.taken[slot]       = 1'b0;
          s.taken_cnt         = s.taken_cnt - 7'd1;
          s.free_cnt          = s.free_cnt + 7'd1;
          r.handle_active_out = 1'b0;
        end
      end
      gtva_pkg::OP_QUERY: r.in_use = s.active && hit && s.taken[slot];
      default: ;  // unused codes leave everything alone
    endcase
    r.allocated_count = s.taken_cnt;
    r.free_count      = s.free_cnt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic gtva_pkg::req_t mk_cmd(logic [2:0] op, logic [7:0] vec,
                                            logic [31:0] g, logic act,
                                            logic irq, logic rdy);
    gtva_pkg::req_t c;
    c.operation         = op;
    c.vector            = vec;
    c.handle_generation = g;
    c.handle_active     = act;
    c.irq_enabled       = irq;
    c.platform_ready    = rdy;
    return c;
  endfunction

  // Run the command through the planning copy so later releases can carry
  // handles that are really live, then queue it for the driver.
  task automatic stage_item(input gtva_pkg::req_t c);
    gtva_pkg::resp_t r;
    int    slot;
    slot = int'(c.vector) - int'(plan.base);
    r = apply_command(plan, c);
    if (r.status == gtva_pkg::ST_OK) begin
      case (c.operation)
        gtva_pkg::OP_INIT: live_handles.delete();
        gtva_pkg::OP_ALLOC_ANY, gtva_pkg::OP_ALLOC_NAMED:
          live_handles.push_back('{int'(r.granted_vector) - int'(plan.base),
                                   r.granted_generation});
        gtva_pkg::OP_RELEASE: begin
          for (int k = live_handles.size() - 1; k >= 0; k--) begin
            if (live_handles[k].slot == slot) begin
              retired_handles.push_back(live_handles[k]);
              live_handles.delete(k);
            end
          end
          if (retired_handles.size() > 32) void'(retired_handles.pop_front());
        end
        default: ;
      endcase
    end
    command_backlog.push_back(c);
  endtask

  function automatic logic [7:0] window_vector();
    return 8'(int'(plan.base) + $urandom_range(NSLOTS - 1));
  endfunction

  // Mostly well-formed traffic: releases use live handles, named requests
  // aim inside the window. The rest is stale, doubled or out-of-window.
  function automatic gtva_pkg::req_t random_command(bit fills);
    gtva_pkg::req_t c;
    handle_t h;
    int      roll;
    int      any_w;
    int      rel_w;
    c.vector            = 8'($urandom);
    c.handle_generation = $urandom;
    c.handle_active     = 1'($urandom);
    c.irq_enabled       = ($urandom_range(99) < 5);
    c.platform_ready    = ($urandom_range(99) < 90);
    any_w = fills ? 44 : 22;
    rel_w = fills ? 22 : 44;
    roll  = $urandom_range(99);
    if (roll < any_w) c.operation = gtva_pkg::OP_ALLOC_ANY;
    else if (roll < any_w + 12) begin
      c.operation = gtva_pkg::OP_ALLOC_NAMED;
      if ($urandom_range(99) < 75) c.vector = window_vector();
    end else if (roll < any_w + 12 + rel_w) begin
      c.operation = gtva_pkg::OP_RELEASE;
      roll = $urandom_range(99);
      if (live_handles.size() != 0 && roll < 85) begin
        h = live_handles[$urandom_range(live_handles.size() - 1)];
        c.vector            = 8'(int'(plan.base) + h.slot);
        c.handle_generation = h.gen;
        c.handle_active     = 1'b1;
        roll = $urandom_range(99);
        if (roll < 8) c.handle_generation = h.gen ^ (32'd1 << $urandom_range(31));
        else if (roll < 14) c.handle_active = 1'b0;
      end else if (retired_handles.size() != 0 && roll < 95) begin
        // handle already given back: double release or stale after reuse
        h = retired_handles[$urandom_range(retired_handles.size() - 1)];
        c.vector            = 8'(int'(plan.base) + h.slot);
        c.handle_generation = h.gen;
        c.handle_active     = 1'b1;
      end
    end else if (roll < any_w + 12 + rel_w + 15) begin
      c.operation = gtva_pkg::OP_QUERY;
      if ($urandom_range(99) < 75) c.vector = window_vector();
    end else if (roll < any_w + 12 + rel_w + 19) c.operation = gtva_pkg::OP_INIT;
    else c.operation = 3'($urandom_range(7, int'(gtva_pkg::OP_QUERY) + 1));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  // Sender holds off until the queue is empty and every result is in.
  task automatic wait_idle();
    do @(posedge clk);
    while (command_backlog.size() != 0 || start || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One window-base transaction; both shadow copies follow at the handshake.
  task automatic write_window(input logic [7:0] base);
    repeat ($urandom_range(3)) @(posedge clk);
    cfg_data  <= base;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    model.base = base;
    plan.base  = base;
    window_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("mismatch on result %0d: %s expected %0h got %0h",
                 results_checked, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: a transaction moves when start && !busy at the edge. The model
  // is stepped right there, so its prediction sees the same state order as
  // the block. start stays high between back-to-back transactions. The
  // offer for the next transaction is decided only at edges where the block
  // is free, so a random gap really shows up as an idle cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(apply_command(model, command));
        void'(command_backlog.pop_front());
        accepted_count++;
      end
      if (!busy) begin
        if (command_backlog.size() != 0 &&
            (steady_feed || $urandom_range(99) >= IDLE_PCT)) begin
          start   <= 1'b1;
          command <= command_backlog[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: done is a one-cycle strobe, taken at the edge that ends it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    gtva_pkg::resp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: status %0d vector %0d", result.status,
                   result.granted_vector);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("granted_vector", 32'(want.granted_vector),
                    32'(result.granted_vector));
        check_field("granted_generation", want.granted_generation,
                    result.granted_generation);
        check_field("handle_active_out", 32'(want.handle_active_out),
                    32'(result.handle_active_out));
        check_field("in_use", 32'(want.in_use), 32'(result.in_use));
        check_field("allocated_count", 32'(want.allocated_count),
                    32'(result.allocated_count));
        check_field("free_count", 32'(want.free_count), 32'(result.free_count));
        status_tally[want.status]++;
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    model = cleared_state();
    plan  = cleared_state();
    foreach (status_tally[k]) status_tally[k] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset window base, nothing initialized yet
    steady_feed = 1'b0;
    stage_item(mk_cmd(gtva_pkg::OP_QUERY, 8'd64, '0, 1'b0, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_ANY, 8'd0, '0, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd64, 32'd1, 1'b1, 1'b0, 1'b1));
    // initialize: platform down, then irq on, then clean
    stage_item(mk_cmd(gtva_pkg::OP_INIT, 8'd0, '0, 1'b0, 1'b0, 1'b0));
    stage_item(mk_cmd(gtva_pkg::OP_INIT, 8'd0, '0, 1'b0, 1'b1, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_INIT, 8'd0, '0, 1'b1, 1'b0, 1'b1));
    // second initialize reports already-active ahead of the irq check
    stage_item(mk_cmd(gtva_pkg::OP_INIT, 8'd0, '0, 1'b0, 1'b1, 1'b0));
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_ANY, 8'd0, '0, 1'b0, 1'b1, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_ANY, 8'd255, 32'hFFFF_FFFF,
                      1'b0, 1'b0, 1'b0));
    // named: taken, just below window, last slot, just above window
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_NAMED, 8'd64, '0, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_NAMED, 8'd63, '0, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_NAMED, 8'd127, '0, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_NAMED, 8'd128, '0, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_QUERY, 8'd127, '0, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_QUERY, 8'd255, '0, 1'b1, 1'b0, 1'b1));
    // release: stale tag, inactive handle, irq, good, then double
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd64, 32'hFFFF_FFFF,
                      1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd64, 32'd1, 1'b0, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd64, 32'd1, 1'b1, 1'b1, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd64, 32'd1, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd64, 32'd1, 1'b1, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_RELEASE, 8'd0, '0, 1'b1, 1'b0, 1'b1));
    // unused operation codes are ignored
    for (int k = int'(gtva_pkg::OP_QUERY) + 1; k < 8; k++)
      stage_item(mk_cmd(3'(k), 8'd64, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    // slot 0 again: generation moves to 2
    stage_item(mk_cmd(gtva_pkg::OP_ALLOC_ANY, 8'd0, '0, 1'b0, 1'b0, 1'b1));
    stage_item(mk_cmd(gtva_pkg::OP_QUERY, 8'd64, '0, 1'b0, 1'b0, 1'b1));
    wait_idle();

    // Random phases; each starts from an idle block with a new window base.
    // Phase 0 runs with no sender gaps at all.
    for (int p = 0; p < PHASES; p++) begin
      write_window(PHASE_BASE[p]);
      steady_feed = (p == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        stage_item(random_command(PHASE_FILLS[p]));
      wait_idle();
    end

    fail_count += pending_results.size();
    $display("%0d transactions, %0d results checked, %0d window writes, %0d cycles",
             accepted_count, results_checked, window_writes, cycle_count);
    $display({"status mix: ok %0d already %0d not-init %0d irq %0d reserved %0d",
              " taken %0d exhausted %0d double %0d stale %0d"},
             status_tally[gtva_pkg::ST_OK], status_tally[gtva_pkg::ST_ALREADY],
             status_tally[gtva_pkg::ST_NOT_INIT], status_tally[gtva_pkg::ST_IRQ],
             status_tally[gtva_pkg::ST_RESERVED], status_tally[gtva_pkg::ST_TAKEN],
             status_tally[gtva_pkg::ST_EXHAUSTED], status_tally[gtva_pkg::ST_DOUBLE],
             status_tally[gtva_pkg::ST_STALE]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
